>>> rtl/bitmap_frame_allocator_core_macros.svh
// assertion macros used by the frame allocator rtl
`ifndef BITMAP_FRAME_ALLOCATOR_CORE_MACROS_SVH
`define BITMAP_FRAME_ALLOCATOR_CORE_MACROS_SVH

// condition and consequence in the same cycle
`define BFA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// consequence in the cycle after the condition
`define BFA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/bfa_pkg.sv
// constants, types and helper functions of the frame allocator
package bfa_pkg;

    localparam int MAP_WORDS      = 256;
    localparam int PAGE_BYTES     = 4096;
    localparam int RESERVED_WORDS = 8;

    localparam int WORD_BITS  = 64;
    localparam int BIT_W      = 6;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int WORD_W     = $clog2(MAP_WORDS);
    localparam int FRAME_W    = WORD_W + BIT_W;
    localparam int FRAMES     = MAP_WORDS * WORD_BITS;
    localparam int HINT_W     = FRAME_W + 1;

    // fixed field widths
    localparam int FREE_ADDR_W  = 32;
    localparam int ALLOC_ADDR_W = 26;
    localparam int COUNT_W      = 15;
    localparam int STATUS_W     = 2;

    // two level summary of nonempty words
    localparam int GRP_SIZE  = 16;
    localparam int GRP_OFF_W = 4;
    localparam int N_GRP     = (MAP_WORDS + GRP_SIZE - 1) / GRP_SIZE;
    localparam int GRP_IDX_W = (N_GRP > 1) ? $clog2(N_GRP) : 1;
    localparam int SUM_W     = N_GRP * GRP_SIZE;
    localparam int PAD_W     = GRP_IDX_W + GRP_OFF_W;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_ALLOCATED = 2'd0,
        ST_OOM       = 2'd1,
        ST_FREED     = 2'd2,
        ST_IGNORED   = 2'd3
    } t_status;

    function automatic logic [GRP_OFF_W-1:0] lowest16(input logic [GRP_SIZE-1:0] v);
        logic [GRP_OFF_W-1:0] r;
        r = '0;
        for (int i = GRP_SIZE - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = GRP_OFF_W'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [BIT_W-1:0] lowest64(input logic [WORD_BITS-1:0] v);
        logic [BIT_W-1:0] r;
        r = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = BIT_W'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [GRP_IDX_W-1:0] lowest_grp(input logic [N_GRP-1:0] v);
        logic [GRP_IDX_W-1:0] r;
        r = '0;
        for (int i = N_GRP - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = GRP_IDX_W'(i);
            end
        end
        return r;
    endfunction

    // map word content after reset
    function automatic logic [WORD_BITS-1:0] reset_word(input logic [WORD_W-1:0] w);
        return (int'(w) < RESERVED_WORDS) ? '0 : '1;
    endfunction

    function automatic logic [SUM_W-1:0] sum_reset();
        logic [SUM_W-1:0] s;
        s = '0;
        for (int i = 0; i < SUM_W; i++) begin
            s[i] = (i >= RESERVED_WORDS) && (i < MAP_WORDS);
        end
        return s;
    endfunction

    function automatic logic [N_GRP-1:0] grp_reset();
        logic [SUM_W-1:0] s;
        logic [N_GRP-1:0] g;
        s = sum_reset();
        g = '0;
        for (int i = 0; i < N_GRP; i++) begin
            g[i] = |s[i*GRP_SIZE +: GRP_SIZE];
        end
        return g;
    endfunction

endpackage

>>> rtl/bfa_req_if.sv
// request channel of the frame allocator
interface bfa_req_if;
    logic                               valid;
    logic                               ready;
    logic                               func;
    logic [bfa_pkg::FREE_ADDR_W-1:0]    free_address;

    modport source (output valid, output func, output free_address, input ready);
    modport sink   (input valid, input func, input free_address, output ready);
endinterface

>>> rtl/bfa_rsp_if.sv
// response channel of the frame allocator
interface bfa_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [bfa_pkg::ALLOC_ADDR_W-1:0]   alloc_address;
    logic [bfa_pkg::STATUS_W-1:0]       status;
    logic [bfa_pkg::COUNT_W-1:0]        free_frames;

    modport source (output valid, output alloc_address, output status, output free_frames,
                    input ready);
    modport sink   (input valid, input alloc_address, input status, input free_frames,
                    output ready);
endinterface

>>> rtl/bitmap_frame_allocator_core.sv
// bitmap page frame allocator core with search summary and map memory
// The block hands out and takes back 4 KiB page frames tracked in a map memory
// of 256 words of 64 bits, a 1 bit meaning free; the first 512 frames come out of
// reset reserved. Each request word gives exactly one response word carrying the
// status and the free frame count. An allocate passes the states FIND, RD and MOD
// after its accept when a free frame lies in the 16-word group that holds the
// next-fit hint, and FIND, GRP, RD and MOD when the search jumps to a later group;
// an out-of-memory answer passes FIND and MOD, and a free passes RD and MOD. MOD
// loads the response register, and the next request word is taken in the cycle
// after; MOD holds for as long as a previous response still waits in the output
// register. The steps are the search over the summary of nonempty words, the
// registered read of the map memory and the read-modify-write of the chosen word.
// One request is in flight at a time, while a finished response may still wait in
// the output register. The map needs no clearing pass after reset: a valid bit per
// word makes an unwritten word read as its reset content, so requests are taken
// from the first cycle.
`include "bitmap_frame_allocator_core_macros.svh"

module bitmap_frame_allocator_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bfa_req_if.sink      i_req,
    bfa_rsp_if.source    o_rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_GRP,
        S_RD,
        S_MOD
    } t_state;

    t_state                                 r_state;

    // request context
    logic                                   r_func;
    logic                                   r_oom;
    logic                                   r_oor;
    logic [bfa_pkg::WORD_W-1:0]             r_word;
    logic [bfa_pkg::BIT_W-1:0]              r_bit;
    logic [bfa_pkg::GRP_IDX_W-1:0]          r_grp;

    // allocator state besides the map
    logic [bfa_pkg::HINT_W-1:0]             r_hint;
    logic [bfa_pkg::COUNT_W-1:0]            r_free;
    logic [bfa_pkg::SUM_W-1:0]              r_sum;
    logic [bfa_pkg::N_GRP-1:0]              r_grp_sum;
    logic [bfa_pkg::MAP_WORDS-1:0]          r_vld;

    // map memory and its read register
    logic [bfa_pkg::WORD_BITS-1:0]          r_map [bfa_pkg::MAP_WORDS];
    logic [bfa_pkg::WORD_BITS-1:0]          r_rdata;
    logic                                   r_rvld;

    // response register
    logic                                   r_out_vld;
    logic [bfa_pkg::ALLOC_ADDR_W-1:0]       r_out_addr;
    bfa_pkg::t_status                       r_out_status;
    logic [bfa_pkg::COUNT_W-1:0]            r_out_free;

    // search signals
    logic [bfa_pkg::WORD_W-1:0]             w_hint_word;
    logic [bfa_pkg::PAD_W-1:0]              w_hint_pad;
    logic [bfa_pkg::GRP_IDX_W-1:0]          w_hint_grp;
    logic [bfa_pkg::GRP_OFF_W-1:0]          w_hint_off;
    logic                                   w_hint_ovf;
    logic [bfa_pkg::GRP_SIZE-1:0]           w_chunk_h;
    logic [bfa_pkg::GRP_SIZE-1:0]           w_m0;
    logic [bfa_pkg::N_GRP-1:0]              w_above;
    logic [bfa_pkg::GRP_SIZE-1:0]           w_chunk_g;

    // update signals
    logic                                   w_go;
    logic [bfa_pkg::WORD_BITS-1:0]          w_cur_word;
    logic [bfa_pkg::BIT_W-1:0]              w_sel_bit;
    logic [bfa_pkg::FRAME_W-1:0]            w_frame;
    logic                                   w_free_hit;
    logic [bfa_pkg::WORD_BITS-1:0]          w_wdata;
    logic                                   w_do_alloc;
    logic                                   w_do_write;
    logic [bfa_pkg::SUM_W-1:0]              n_sum;
    logic [bfa_pkg::PAD_W-1:0]              w_word_pad;
    logic [bfa_pkg::GRP_IDX_W-1:0]          w_word_grp;
    logic                                   n_grp_bit;

    assign i_req.ready         = (r_state == S_IDLE);
    assign o_rsp.valid         = r_out_vld;
    assign o_rsp.alloc_address = r_out_addr;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.free_frames   = r_out_free;

    // response slot is free or being emptied this cycle
    assign w_go = !r_out_vld || o_rsp.ready;

    // search from the hint word: first its own group above the hint, then later groups
    always_comb begin
        w_hint_word = r_hint[bfa_pkg::FRAME_W-1:bfa_pkg::BIT_W];
        w_hint_ovf  = (r_hint >= bfa_pkg::HINT_W'(bfa_pkg::FRAMES));
        w_hint_pad  = bfa_pkg::PAD_W'(w_hint_word);
        w_hint_grp  = w_hint_pad[bfa_pkg::PAD_W-1:bfa_pkg::GRP_OFF_W];
        w_hint_off  = w_hint_pad[bfa_pkg::GRP_OFF_W-1:0];
        w_chunk_h   = r_sum[{w_hint_grp, bfa_pkg::GRP_OFF_W'(0)} +: bfa_pkg::GRP_SIZE];
        w_m0        = w_chunk_h & ~((bfa_pkg::GRP_SIZE'(1) << w_hint_off)
                                    - bfa_pkg::GRP_SIZE'(1));
        w_above     = r_grp_sum & (({bfa_pkg::N_GRP{1'b1}} << w_hint_grp) << 1);
        w_chunk_g   = r_sum[{r_grp, bfa_pkg::GRP_OFF_W'(0)} +: bfa_pkg::GRP_SIZE];
    end

    // read-modify-write of the map word
    always_comb begin
        w_cur_word = r_rvld ? r_rdata : bfa_pkg::reset_word(r_word);
        w_sel_bit  = bfa_pkg::lowest64(w_cur_word);
        w_frame    = {r_word, w_sel_bit};
        w_free_hit = !r_oor && !w_cur_word[r_bit];
        if (r_func == bfa_pkg::FUNC_FREE) begin
            w_wdata = w_cur_word | (bfa_pkg::WORD_BITS'(1) << r_bit);
        end else begin
            w_wdata = w_cur_word & ~(bfa_pkg::WORD_BITS'(1) << w_sel_bit);
        end
        w_do_alloc = (r_state == S_MOD) && w_go && (r_func == bfa_pkg::FUNC_ALLOC) && !r_oom;
        w_do_write = w_do_alloc
                     || ((r_state == S_MOD) && w_go && (r_func == bfa_pkg::FUNC_FREE)
                         && w_free_hit);
        // keep summary levels in step with the written word
        n_sum         = r_sum;
        n_sum[r_word] = |w_wdata;
        w_word_pad    = bfa_pkg::PAD_W'(r_word);
        w_word_grp    = w_word_pad[bfa_pkg::PAD_W-1:bfa_pkg::GRP_OFF_W];
        n_grp_bit     = |n_sum[{w_word_grp, bfa_pkg::GRP_OFF_W'(0)} +: bfa_pkg::GRP_SIZE];
    end

    // map memory, read every cycle at the current word
    always_ff @(posedge i_clk) begin
        if (w_do_write) begin
            r_map[r_word] <= w_wdata;
        end
        r_rdata <= r_map[r_word];
        r_rvld  <= r_vld[r_word];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
            r_hint    <= '0;
            r_free    <= bfa_pkg::COUNT_W'(bfa_pkg::FRAMES
                                           - bfa_pkg::RESERVED_WORDS * bfa_pkg::WORD_BITS);
            r_sum     <= bfa_pkg::sum_reset();
            r_grp_sum <= bfa_pkg::grp_reset();
            r_vld     <= '0;
            r_func    <= bfa_pkg::FUNC_ALLOC;
            r_oom     <= 1'b0;
            r_oor     <= 1'b0;
        end else begin
            if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_func <= i_req.func;
                        r_oom  <= 1'b0;
                        r_oor  <= |i_req.free_address[bfa_pkg::FREE_ADDR_W-1:
                                                      bfa_pkg::PAGE_SHIFT + bfa_pkg::FRAME_W];
                        r_word <= i_req.free_address[bfa_pkg::PAGE_SHIFT + bfa_pkg::FRAME_W - 1:
                                                     bfa_pkg::PAGE_SHIFT + bfa_pkg::BIT_W];
                        r_bit  <= i_req.free_address[bfa_pkg::PAGE_SHIFT + bfa_pkg::BIT_W - 1:
                                                     bfa_pkg::PAGE_SHIFT];
                        if (i_req.func == bfa_pkg::FUNC_FREE) begin
                            r_state <= S_RD;
                        end else begin
                            r_state <= S_FIND;
                        end
                    end
                end
                S_FIND: begin
                    priority if (w_hint_ovf) begin
                        r_oom   <= 1'b1;
                        r_state <= S_MOD;
                    end else if (|w_m0) begin
                        r_word  <= bfa_pkg::WORD_W'({w_hint_grp, bfa_pkg::lowest16(w_m0)});
                        r_state <= S_RD;
                    end else if (|w_above) begin
                        r_grp   <= bfa_pkg::lowest_grp(w_above);
                        r_state <= S_GRP;
                    end else begin
                        r_oom   <= 1'b1;
                        r_state <= S_MOD;
                    end
                end
                S_GRP: begin
                    r_word  <= bfa_pkg::WORD_W'({r_grp, bfa_pkg::lowest16(w_chunk_g)});
                    r_state <= S_RD;
                end
                S_RD: begin
                    // map read data lands in the next cycle
                    r_state <= S_MOD;
                end
                S_MOD: begin
                    if (w_go) begin
                        r_out_vld <= 1'b1;
                        r_state   <= S_IDLE;
                        if (w_do_write) begin
                            r_sum                <= n_sum;
                            r_grp_sum[w_word_grp] <= n_grp_bit;
                            r_vld[r_word]        <= 1'b1;
                        end
                        if (r_func == bfa_pkg::FUNC_ALLOC) begin
                            if (r_oom) begin
                                r_out_addr   <= '0;
                                r_out_status <= bfa_pkg::ST_OOM;
                                r_out_free   <= r_free;
                            end else begin
                                r_hint       <= bfa_pkg::HINT_W'(w_frame) + 1'b1;
                                r_free       <= r_free - 1'b1;
                                r_out_addr   <= bfa_pkg::ALLOC_ADDR_W'(
                                                    {w_frame, bfa_pkg::PAGE_SHIFT'(0)});
                                r_out_status <= bfa_pkg::ST_ALLOCATED;
                                r_out_free   <= r_free - 1'b1;
                            end
                        end else begin
                            r_out_addr <= '0;
                            if (w_free_hit) begin
                                r_free       <= r_free + 1'b1;
                                r_out_status <= bfa_pkg::ST_FREED;
                                r_out_free   <= r_free + 1'b1;
                            end else begin
                                r_out_status <= bfa_pkg::ST_IGNORED;
                                r_out_free   <= r_free;
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // the summary must only ever point the allocator at a word with a free frame
    `BFA_ASSERT_SAME(a_alloc_word_nonempty, i_clk, i_rst_n, w_do_alloc, w_cur_word != '0, "summary points at an empty map word")

    // finishing a request always loads the response register
    `BFA_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, (r_state == S_MOD) && w_go, o_rsp.valid, "finished request gave no response")

    // a successful free raises the count by exactly one
    `BFA_ASSERT_NEXT(a_free_counts_up, i_clk, i_rst_n, w_do_write && (r_func == bfa_pkg::FUNC_FREE), r_free == $past(r_free) + 1'b1, "free count not raised by one")

endmodule

>>> dv/bitmap_frame_allocator_core_tb.sv
// self-checking testbench for the bitmap page frame allocator core
`timescale 1ns / 1ps

module bitmap_frame_allocator_core_tb;
    import bfa_pkg::*;

    // one response word as the block should return it
    typedef struct packed {
        logic [ALLOC_ADDR_W-1:0] addr;
        t_status                 st;
        logic [COUNT_W-1:0]      cnt;
    } frame_result_t;

    // directed row: request word, and its response where it can be read off directly
    typedef struct packed {
        logic              func;
        logic [31:0]       addr;
        logic              typed;
        frame_result_t     want;
    } frame_row_t;

    localparam int N_ROWS = 16;
    localparam int N_RANDOM = 1834;
    localparam int FREE_AT_RESET = (MAP_WORDS - RESERVED_WORDS) * WORD_BITS;

    logic i_clk;
    logic i_rst_n;

    bfa_req_if req_if ();
    bfa_rsp_if rsp_if ();

    bitmap_frame_allocator_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always #2 i_clk = ~i_clk;

    // own copy of the allocator state
    logic [WORD_BITS-1:0] frame_free_map [MAP_WORDS];
    int                   free_count;
    int                   next_fit_hint;

    frame_result_t pending_results [$];
    int            used_frames [$];
    int            err_cnt;
    int            n_checked;
    int            n_alloc;
    int            n_oom;
    int            n_freed;
    int            n_ignored;
    bit            steady;

    // reserved-frame hits, reuse inside the hint word, double frees, out-of-range frees
    frame_row_t directed_rows [N_ROWS] = '{
        '{FUNC_ALLOC, 32'h0000_0000, 1'b1, '{26'h0200000, ST_ALLOCATED, 15'd15871}},
        '{FUNC_ALLOC, 32'hFFFF_FFFF, 1'b1, '{26'h0201000, ST_ALLOCATED, 15'd15870}},
        '{FUNC_FREE,  32'h0020_0000, 1'b1, '{26'h0,       ST_FREED,     15'd15871}},
        '{FUNC_FREE,  32'h0020_0000, 1'b1, '{26'h0,       ST_IGNORED,   15'd15871}},
        '{FUNC_ALLOC, 32'h0000_0000, 1'b1, '{26'h0200000, ST_ALLOCATED, 15'd15870}},
        '{FUNC_FREE,  32'h0000_0000, 1'b1, '{26'h0,       ST_FREED,     15'd15871}},
        '{FUNC_FREE,  32'h0000_0FFF, 1'b1, '{26'h0,       ST_IGNORED,   15'd15871}},
        '{FUNC_FREE,  32'hFFFF_FFFF, 1'b1, '{26'h0,       ST_IGNORED,   15'd15871}},
        '{FUNC_FREE,  32'h0400_0000, 1'b1, '{26'h0,       ST_IGNORED,   15'd15871}},
        '{FUNC_FREE,  32'h03FF_FFFF, 1'b1, '{26'h0,       ST_IGNORED,   15'd15871}},
        '{FUNC_FREE,  32'h001F_F123, 1'b1, '{26'h0,       ST_FREED,     15'd15872}},
        // frames 0 and 511 are free again but sit below the hint
        '{FUNC_ALLOC, 32'hAAAA_AAAA, 1'b0, '0},
        '{FUNC_FREE,  32'h0020_1ABC, 1'b0, '0},
        '{FUNC_ALLOC, 32'h5555_5555, 1'b0, '0},
        '{FUNC_FREE,  32'hAAAA_AAAA, 1'b1, '{26'h0,       ST_IGNORED,   15'd15871}},
        '{FUNC_FREE,  32'h5555_5555, 1'b1, '{26'h0,       ST_IGNORED,   15'd15871}}
    };

    // next-fit allocate or checked free, updating the local state copy
    function automatic frame_result_t allocate_or_free(input logic f, input logic [31:0] a);
        frame_result_t r;
        int            w;
        int            b;
        int            frame;
        bit            found;
        r = '0;
        found = 1'b0;
        if (f == FUNC_ALLOC) begin
            r.st = ST_OOM;
            // no wrap-around: words below the hint word are never looked at
            for (w = next_fit_hint / WORD_BITS; w < MAP_WORDS && !found; w++) begin
                if (frame_free_map[w] != '0) begin
                    for (b = 0; b < WORD_BITS && !found; b++) begin
                        if (frame_free_map[w][b]) begin
                            found = 1'b1;
                            frame = w * WORD_BITS + b;
                            frame_free_map[w][b] = 1'b0;
                            free_count--;
                            next_fit_hint = frame + 1;
                            used_frames.push_back(frame);
                            r.addr = ALLOC_ADDR_W'(frame * PAGE_BYTES);
                            r.st = ST_ALLOCATED;
                        end
                    end
                end
            end
        end else begin
            frame = int'(a >> PAGE_SHIFT);
            if (frame < FRAMES && !frame_free_map[frame / WORD_BITS][frame % WORD_BITS]) begin
                frame_free_map[frame / WORD_BITS][frame % WORD_BITS] = 1'b1;
                free_count++;
                r.st = ST_FREED;
            end else begin
                r.st = ST_IGNORED;
            end
        end
        r.cnt = COUNT_W'(free_count);
        return r;
    endfunction

    // offer one request word, wait for it to be taken, then book its response
    task automatic send_word(input logic f, input logic [31:0] a,
                             input logic typed, input frame_result_t want);
        frame_result_t r;
        while (!steady && $urandom_range(0, 99) < 15) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid        <= 1'b1;
        req_if.func         <= f;
        req_if.free_address <= a;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        r = allocate_or_free(f, a);
        if (typed) r = want;
        case (r.st)
            ST_ALLOCATED: n_alloc++;
            ST_OOM:       n_oom++;
            ST_FREED:     n_freed++;
            default:      n_ignored++;
        endcase
        pending_results.push_back(r);
    endtask

    // mixed traffic: allocates, and frees mostly of frames in use, some of random in-map and wild addresses
    task automatic random_word(input int alloc_pct);
        int          pick;
        int          idx;
        int          frame;
        logic [31:0] a;
        if ($urandom_range(0, 99) < alloc_pct) begin
            send_word(FUNC_ALLOC, $urandom(), 1'b0, '0);
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 70 && used_frames.size() > 0) begin
                idx = $urandom_range(0, used_frames.size() - 1);
                frame = used_frames[idx];
                used_frames.delete(idx);
                a = (32'(frame) << PAGE_SHIFT) | 32'($urandom_range(0, PAGE_BYTES - 1));
            end else if (pick < 85) begin
                a = (32'($urandom_range(0, FRAMES - 1)) << PAGE_SHIFT)
                    | 32'($urandom_range(0, PAGE_BYTES - 1));
            end else begin
                a = $urandom();
            end
            send_word(FUNC_FREE, a, 1'b0, '0);
        end
    endtask

    // response side: random back-pressure and in-order compare
    always @(posedge i_clk) begin : rsp_side
        frame_result_t want;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= steady || ($urandom_range(0, 99) >= 15);
            if (rsp_if.valid && rsp_if.ready) begin
                n_checked++;
                if (pending_results.size() == 0) begin
                    $error("response word with nothing outstanding");
                    err_cnt++;
                end else begin
                    want = pending_results.pop_front();
                    if (rsp_if.alloc_address !== want.addr) begin
                        $error("alloc_address expected %h got %h", want.addr,
                               rsp_if.alloc_address);
                        err_cnt++;
                    end
                    if (rsp_if.status !== want.st) begin
                        $error("status expected %0d got %0d", want.st, rsp_if.status);
                        err_cnt++;
                    end
                    if (rsp_if.free_frames !== want.cnt) begin
                        $error("free_frames expected %0d got %0d", want.cnt,
                               rsp_if.free_frames);
                        err_cnt++;
                    end
                end
            end
        end
    end

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.func = FUNC_ALLOC;
        req_if.free_address = '0;
        rsp_if.ready = 1'b0;
        steady = 1'b0;
        err_cnt = 0;
        n_checked = 0;
        n_alloc = 0;
        n_oom = 0;
        n_freed = 0;
        n_ignored = 0;
        for (int w = 0; w < MAP_WORDS; w++) begin
            frame_free_map[w] = (w < RESERVED_WORDS) ? '0 : '1;
        end
        free_count = FREE_AT_RESET;
        next_fit_hint = 0;
        // reserved frames start out in use
        for (int f = 0; f < RESERVED_WORDS * WORD_BITS; f++) begin
            used_frames.push_back(f);
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_ROWS; i++) begin
            send_word(directed_rows[i].func, directed_rows[i].addr,
                      directed_rows[i].typed, directed_rows[i].want);
        end

        // mixed traffic with a stretch of no idling on either side
        for (int i = 0; i < N_RANDOM; i++) begin
            steady = (i >= 600 && i < 900);
            random_word((i < 900) ? 55 : 40);
        end
        steady = 1'b0;
        req_if.valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("%0d responses checked: %0d allocated, %0d out of memory, %0d freed, %0d ignored",
                 n_checked, n_alloc, n_oom, n_freed, n_ignored);
        $display("next-fit hint ended at %0d with %0d frames still free",
                 next_fit_hint, free_count);
        if (err_cnt == 0) begin
            $display("bitmap_frame_allocator_core: match");
        end else begin
            $display("bitmap_frame_allocator_core: mismatch");
        end
        $finish;
    end

    // watchdog
    initial begin
        #4_000_000;
        $display("bitmap_frame_allocator_core: mismatch");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/bfa_pkg.sv
rtl/bfa_req_if.sv
rtl/bfa_rsp_if.sv
rtl/bitmap_frame_allocator_core.sv
dv/bitmap_frame_allocator_core_tb.sv
